// ===== rtl/core/sdspi_pkg.sv =====
// Shared types and constants for the SD card SPI-mode init sequencer.
`default_nettype none

package sdspi_pkg;

    // Request codes carried in the op field
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_RX    = 2'd3
    } t_op;

    // One input transaction
    typedef struct packed {
        t_op         op;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       select_active;
        logic       full_speed;
        logic       success;
        logic       high_capacity;
    } t_out_item;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Polling and retry limits
    localparam logic [15:0] POLL_LIMIT  = 16'hFFFF;
    localparam logic [7:0]  RETRY_LIMIT = 8'hFF;

    // Frame positions: dummy, command, four argument bytes, CRC, then polling
    localparam logic [2:0] IDX_CRC  = 3'd6;
    localparam logic [2:0] IDX_POLL = 3'd7;
    localparam logic [2:0] IDX_REPLY_LAST = 3'd3;

    // Byte values
    localparam logic [7:0]  BYTE_IDLE  = 8'hFF;
    localparam logic [7:0]  CRC_CMD0   = 8'h95;
    localparam logic [7:0]  CRC_CMD8   = 8'h87;
    localparam logic [7:0]  R7_CHECK   = 8'hAA;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
    localparam logic [31:0] ARG_BLKLEN = 32'd512;

    // Command bytes (start bit pattern 0x40 with the command index)
    localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
    localparam logic [7:0] CMD_SEND_OP   = 8'h41;
    localparam logic [7:0] CMD_IF_COND   = 8'h48;
    localparam logic [7:0] CMD_BLOCKLEN  = 8'h50;
    localparam logic [7:0] CMD_READ_BLK  = 8'h51;
    localparam logic [7:0] CMD_WRITE_BLK = 8'h58;
    localparam logic [7:0] CMD_APP_OP    = 8'h69;
    localparam logic [7:0] CMD_APP       = 8'h77;
    localparam logic [7:0] CMD_READ_OCR  = 8'h7A;

endpackage

`default_nettype wire

// ===== rtl/core/sdspi_in_stage.sv =====
// Input register that captures one request or received-byte transaction.
`default_nettype none

module sdspi_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  sdspi_pkg::t_in_item i_item,
    input  wire                 i_take,
    output logic                o_valid,
    output sdspi_pkg::t_in_item o_item
);
    import sdspi_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Hold while a captured transaction waits for the core
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Refill whenever the register is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= i_valid;
        end
        if ((!r_valid || i_take) && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdspi_core.sv =====
// Sequencer state and the combinational next-byte decision logic.
`default_nettype none

module sdspi_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  sdspi_pkg::t_in_item  i_item,
    output logic                 o_res_valid,
    output sdspi_pkg::t_out_item o_res
);
    import sdspi_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD0, PH_CMD8, PH_R7, PH_HC55, PH_HC41, PH_CMD58,
        PH_OCR, PH_FB55, PH_FB41, PH_CMD1, PH_CMD16, PH_READ, PH_WRITE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_arg, n_arg;
    logic [15:0] r_poll, n_poll;
    logic [7:0]  r_retry, n_retry;
    logic        r_hc, n_hc;
    logic        r_speed, n_speed;
    // Only the bits later inspected are kept from the reply bytes
    logic        r_b0_hcs, n_b0_hcs;
    logic [3:0]  r_b2_lo, n_b2_lo;

    // Combinational working values
    logic        go;
    t_phase      go_ph;
    logic [31:0] go_arg;
    logic        fin;
    logic        fin_ok;
    logic        rt;
    t_phase      rt_first;
    t_phase      rt_fb;
    logic [7:0]  retry_inc;
    logic        idle_ok;
    logic [7:0]  rx;
    logic        res_valid;
    logic        res_kind;
    logic [7:0]  res_tx;
    logic        res_ok;

    // Command byte for a phase
    function automatic logic [7:0] cmd_byte(input t_phase ph);
        logic [7:0] b;
        unique case (ph)
            PH_CMD0:          b = CMD_GO_IDLE;
            PH_CMD8:          b = CMD_IF_COND;
            PH_HC55, PH_FB55: b = CMD_APP;
            PH_HC41, PH_FB41: b = CMD_APP_OP;
            PH_CMD58:         b = CMD_READ_OCR;
            PH_CMD1:          b = CMD_SEND_OP;
            PH_CMD16:         b = CMD_BLOCKLEN;
            PH_READ:          b = CMD_READ_BLK;
            default:          b = CMD_WRITE_BLK;
        endcase
        return b;
    endfunction

    // Byte of the command frame at a given position
    function automatic logic [7:0] frame_byte(input logic [2:0] idx, input t_phase ph,
                                              input logic [31:0] arg);
        logic [7:0] b;
        unique case (idx)
            3'd1:    b = cmd_byte(ph);
            3'd2:    b = arg[31:24];
            3'd3:    b = arg[23:16];
            3'd4:    b = arg[15:8];
            3'd5:    b = arg[7:0];
            IDX_CRC: b = (ph == PH_CMD8) ? CRC_CMD8 : CRC_CMD0;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

    // Decide the next byte or completion and the next state
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_arg    = r_arg;
        n_poll   = r_poll;
        n_retry  = r_retry;
        n_hc     = r_hc;
        n_speed  = r_speed;
        n_b0_hcs = r_b0_hcs;
        n_b2_lo  = r_b2_lo;

        res_valid = 1'b1;
        res_kind  = KIND_TX;
        res_tx    = BYTE_IDLE;
        res_ok    = 1'b0;

        go       = 1'b0;
        go_ph    = PH_IDLE;
        go_arg   = '0;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        rt       = 1'b0;
        rt_first = PH_IDLE;
        rt_fb    = PH_IDLE;

        rx        = i_item.rx_byte;
        idle_ok   = (rx[7:1] == 7'd0);
        retry_inc = r_retry + 8'd1;

        unique case (i_item.op)
            OP_INIT: begin
                n_speed = 1'b0;
                n_hc    = 1'b0;
                n_retry = '0;
                go      = 1'b1;
                go_ph   = PH_CMD0;
            end
            OP_READ, OP_WRITE: begin
                go     = 1'b1;
                go_ph  = (i_item.op == OP_READ) ? PH_READ : PH_WRITE;
                go_arg = r_hc ? i_item.sector : {i_item.sector[22:0], 9'd0};
            end
            default: begin
                if (r_phase == PH_IDLE) begin
                    // Drop stray bytes while idle
                    res_valid = 1'b0;
                end else if (r_phase == PH_R7 || r_phase == PH_OCR) begin
                    if (r_idx < IDX_REPLY_LAST) begin
                        if (r_idx == 3'd0) begin
                            n_b0_hcs = rx[6];
                        end
                        if (r_idx == 3'd2) begin
                            n_b2_lo = rx[3:0];
                        end
                        n_idx = r_idx + 3'd1;
                    end else if (r_phase == PH_R7) begin
                        n_retry = '0;
                        go      = 1'b1;
                        go_ph   = (r_b2_lo == 4'd1 && rx == R7_CHECK) ? PH_HC55 : PH_FB55;
                    end else begin
                        if (r_b0_hcs) begin
                            n_hc = 1'b1;
                        end
                        go     = 1'b1;
                        go_ph  = PH_CMD16;
                        go_arg = ARG_BLKLEN;
                    end
                end else if (r_idx < IDX_CRC) begin
                    n_idx  = r_idx + 3'd1;
                    res_tx = frame_byte(r_idx + 3'd1, r_phase, r_arg);
                end else if (r_idx == IDX_CRC) begin
                    n_idx  = IDX_POLL;
                    n_poll = '0;
                end else if (rx == BYTE_IDLE && r_poll < POLL_LIMIT) begin
                    n_poll = r_poll + 16'd1;
                end else begin
                    // Act on the command response
                    unique case (r_phase)
                        PH_CMD0: begin
                            go     = 1'b1;
                            go_ph  = PH_CMD8;
                            go_arg = ARG_CMD8;
                        end
                        PH_CMD8: begin
                            if (idle_ok) begin
                                n_phase = PH_R7;
                                n_idx   = '0;
                            end else begin
                                n_retry = '0;
                                go      = 1'b1;
                                go_ph   = PH_FB55;
                            end
                        end
                        PH_HC55: begin
                            if (idle_ok) begin
                                go     = 1'b1;
                                go_ph  = PH_HC41;
                                go_arg = ARG_HCS;
                            end else begin
                                rt       = 1'b1;
                                rt_first = PH_HC55;
                                rt_fb    = PH_FB55;
                            end
                        end
                        PH_HC41: begin
                            if (rx == 8'd0) begin
                                go    = 1'b1;
                                go_ph = PH_CMD58;
                            end else begin
                                rt       = 1'b1;
                                rt_first = PH_HC55;
                                rt_fb    = PH_FB55;
                            end
                        end
                        PH_CMD58: begin
                            if (rx == 8'd0) begin
                                n_phase = PH_OCR;
                                n_idx   = '0;
                            end else begin
                                go     = 1'b1;
                                go_ph  = PH_CMD16;
                                go_arg = ARG_BLKLEN;
                            end
                        end
                        PH_FB55: begin
                            if (idle_ok) begin
                                go     = 1'b1;
                                go_ph  = PH_FB41;
                                go_arg = ARG_HCS;
                            end else begin
                                rt       = 1'b1;
                                rt_first = PH_FB55;
                                rt_fb    = PH_CMD1;
                            end
                        end
                        PH_FB41: begin
                            if (rx == 8'd0) begin
                                go     = 1'b1;
                                go_ph  = PH_CMD16;
                                go_arg = ARG_BLKLEN;
                            end else begin
                                rt       = 1'b1;
                                rt_first = PH_FB55;
                                rt_fb    = PH_CMD1;
                            end
                        end
                        PH_CMD1: begin
                            if (rx == 8'd0) begin
                                go     = 1'b1;
                                go_ph  = PH_CMD16;
                                go_arg = ARG_BLKLEN;
                            end else begin
                                rt       = 1'b1;
                                rt_first = PH_CMD1;
                                rt_fb    = PH_IDLE;
                            end
                        end
                        PH_CMD16: begin
                            fin = 1'b1;
                            if (rx == 8'd0) begin
                                n_speed = 1'b1;
                                fin_ok  = 1'b1;
                            end
                        end
                        default: begin
                            fin    = 1'b1;
                            fin_ok = (rx == 8'd0);
                        end
                    endcase
                end
            end
        endcase

        // Failed try: retry, or move on to the fallback (or finish if none) once the limit is hit
        if (rt) begin
            if (retry_inc >= RETRY_LIMIT) begin
                n_retry = '0;
                if (rt_fb == PH_IDLE) begin
                    fin = 1'b1;
                end else begin
                    go    = 1'b1;
                    go_ph = rt_fb;
                end
            end else begin
                n_retry = retry_inc;
                go      = 1'b1;
                go_ph   = rt_first;
            end
        end

        // Open a new command frame
        if (go) begin
            n_phase = go_ph;
            n_idx   = '0;
            n_arg   = go_arg;
            n_poll  = '0;
        end

        // Complete the request
        if (fin) begin
            n_phase  = PH_IDLE;
            n_idx    = '0;
            res_kind = KIND_DONE;
            res_tx   = 8'd0;
            res_ok   = fin_ok;
        end
    end

    assign o_res_valid         = res_valid;
    assign o_res.kind          = res_kind;
    assign o_res.tx_byte       = res_tx;
    assign o_res.select_active = (res_kind == KIND_TX);
    assign o_res.full_speed    = n_speed;
    assign o_res.success       = res_ok;
    assign o_res.high_capacity = n_hc;

    // Advance the state on every taken transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_arg   <= '0;
            r_poll  <= '0;
            r_retry <= '0;
            r_hc    <= 1'b0;
            r_speed <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_arg   <= n_arg;
            r_poll  <= n_poll;
            r_retry <= n_retry;
            r_hc    <= n_hc;
            r_speed <= n_speed;
        end
        if (i_fire) begin
            r_b0_hcs <= n_b0_hcs;
            r_b2_lo  <= n_b2_lo;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sdspi_out_stage.sv =====
// Result register that holds one outgoing transaction until it is taken.
`default_nettype none

module sdspi_out_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire                  i_res_valid,
    input  sdspi_pkg::t_out_item i_res,
    output logic                 o_advance,
    output logic                 o_valid,
    input  wire                  i_stall,
    output sdspi_pkg::t_out_item o_item
);
    import sdspi_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Free to load when empty or when the held result leaves this cycle
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_res_valid;
        end
        if (o_advance && i_fire && i_res_valid) begin
            r_item <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sd_spi_card_init_sequencer.sv =====
// Top level of the SD card SPI-mode init, read and write start sequencer.
// Path: the input register, the combinational decision logic, then the
// result register. Throughput: one transaction per cycle while the output
// is not stalled; the input register drains into the result register.
// Reset (synchronous, active low) returns to idle, clears the speed and
// high-capacity flags and empties both registers.
`default_nettype none

module sd_spi_card_init_sequencer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  sdspi_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sdspi_pkg::t_out_item o_out_item
);
    import sdspi_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    logic      advance;
    logic      fire;
    logic      res_valid;
    t_out_item res;

    // Take the held transaction whenever the result register can load
    assign fire = in_valid && advance;

    sdspi_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    sdspi_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sdspi_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sdspi_checker.sv =====
// Port-level checks for the sequencer, bound to its top level.
`default_nettype none

module sdspi_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input sdspi_pkg::t_out_item o_out_item
);
    import sdspi_pkg::*;

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Select is driven for byte transactions only
    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.select_active == (o_out_item.kind == KIND_TX)))
        else $error("select level does not match result kind");

    // Completions carry no byte, byte transactions carry no success
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.kind == KIND_DONE && o_out_item.tx_byte == 8'd0)
                         || (o_out_item.kind == KIND_TX && !o_out_item.success)))
        else $error("result fields inconsistent with kind");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind sd_spi_card_init_sequencer sdspi_checker u_sdspi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== verif/sd_spi_card_init_sequencer_checker.sv =====
// Checker for the SD card SPI-mode sequencer: predicts and compares result transactions.
`default_nettype none

module sd_spi_card_init_sequencer_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  sdspi_pkg::t_in_item  i_in_item,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  sdspi_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);

    import sdspi_pkg::*;

    // Where the host is in its command flow
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_GO_IDLE,
        SEQ_IF_COND,
        SEQ_R7,
        SEQ_HC_APP,
        SEQ_HC_OP,
        SEQ_OCR_CMD,
        SEQ_OCR_READ,
        SEQ_FB_APP,
        SEQ_FB_OP,
        SEQ_SEND_OP,
        SEQ_BLOCKLEN,
        SEQ_READ,
        SEQ_WRITE
    } t_seq_phase;

    // Predicted host state
    t_seq_phase  seq_phase;
    logic [2:0]  frame_pos;
    logic [31:0] cmd_arg;
    logic [15:0] poll_cnt;
    logic [7:0]  retry_cnt;
    logic        hc_flag;
    logic [7:0]  reply_b [0:2];
    logic        speed_on;

    // Results the block still owes, oldest first
    t_out_item   awaited_host_out [$];
    int          fail_tally   = 0;
    int          results_seen = 0;

    task automatic clear_model();
        seq_phase  = SEQ_IDLE;
        frame_pos  = '0;
        cmd_arg    = '0;
        poll_cnt   = '0;
        retry_cnt  = '0;
        hc_flag    = 1'b0;
        reply_b[0] = '0;
        reply_b[1] = '0;
        reply_b[2] = '0;
        speed_on   = 1'b0;
    endtask

    task automatic put_result(input logic kind, input logic [7:0] tx, input logic sel,
                              input logic ok);
        t_out_item r;
        r.kind          = kind;
        r.tx_byte       = tx;
        r.select_active = sel;
        r.full_speed    = speed_on;
        r.success       = ok;
        r.high_capacity = hc_flag;
        awaited_host_out.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_result(KIND_TX, b, 1'b1, 1'b0);
    endtask

    // Drop back to idle with a completion
    task automatic put_done(input logic ok);
        seq_phase = SEQ_IDLE;
        frame_pos = '0;
        put_result(KIND_DONE, 8'h00, 1'b0, ok);
    endtask

    task automatic begin_cmd(input t_seq_phase ph, input logic [31:0] arg);
        seq_phase = ph;
        frame_pos = '0;
        cmd_arg   = arg;
        poll_cnt  = '0;
        put_byte(BYTE_IDLE);
    endtask

    task automatic begin_reply(input t_seq_phase ph);
        seq_phase = ph;
        frame_pos = '0;
        put_byte(BYTE_IDLE);
    endtask

    function automatic logic [7:0] cmd_code(input t_seq_phase ph);
        case (ph)
            SEQ_GO_IDLE:           return CMD_GO_IDLE;
            SEQ_IF_COND:           return CMD_IF_COND;
            SEQ_HC_APP, SEQ_FB_APP: return CMD_APP;
            SEQ_HC_OP, SEQ_FB_OP:  return CMD_APP_OP;
            SEQ_OCR_CMD:           return CMD_READ_OCR;
            SEQ_SEND_OP:           return CMD_SEND_OP;
            SEQ_BLOCKLEN:          return CMD_BLOCKLEN;
            SEQ_READ:              return CMD_READ_BLK;
            default:               return CMD_WRITE_BLK;
        endcase
    endfunction

    // Byte of the command frame at the current position
    function automatic logic [7:0] frame_out();
        case (frame_pos)
            3'd1:    return cmd_code(seq_phase);
            3'd2:    return cmd_arg[31:24];
            3'd3:    return cmd_arg[23:16];
            3'd4:    return cmd_arg[15:8];
            3'd5:    return cmd_arg[7:0];
            IDX_CRC: return (seq_phase == SEQ_IF_COND) ? CRC_CMD8 : CRC_CMD0;
            default: return BYTE_IDLE;
        endcase
    endfunction

    // A failed try: go round again, or move to the fallback once the tries run out
    task automatic retry_fail(input t_seq_phase first, input t_seq_phase fallback);
        retry_cnt = retry_cnt + 8'd1;
        if (retry_cnt >= RETRY_LIMIT) begin
            retry_cnt = '0;
            if (fallback == SEQ_FB_APP) begin
                begin_cmd(SEQ_FB_APP, 32'h0);
            end else if (fallback == SEQ_SEND_OP) begin
                begin_cmd(SEQ_SEND_OP, 32'h0);
            end else begin
                put_done(1'b0);
            end
        end else begin
            begin_cmd(first, 32'h0);
        end
    endtask

    // Act on the card's response byte to the current command
    task automatic on_card_reply(input logic [7:0] r);
        logic idle_ok;
        idle_ok = (r[7:1] == 7'd0);
        case (seq_phase)
            SEQ_GO_IDLE: begin
                begin_cmd(SEQ_IF_COND, ARG_CMD8);
            end
            SEQ_IF_COND: begin
                if (idle_ok) begin
                    begin_reply(SEQ_R7);
                end else begin
                    retry_cnt = '0;
                    begin_cmd(SEQ_FB_APP, 32'h0);
                end
            end
            SEQ_HC_APP: begin
                if (idle_ok) begin_cmd(SEQ_HC_OP, ARG_HCS);
                else retry_fail(SEQ_HC_APP, SEQ_FB_APP);
            end
            SEQ_HC_OP: begin
                if (r == 8'h00) begin_cmd(SEQ_OCR_CMD, 32'h0);
                else retry_fail(SEQ_HC_APP, SEQ_FB_APP);
            end
            SEQ_OCR_CMD: begin
                if (r == 8'h00) begin_reply(SEQ_OCR_READ);
                else begin_cmd(SEQ_BLOCKLEN, ARG_BLKLEN);
            end
            SEQ_FB_APP: begin
                if (idle_ok) begin_cmd(SEQ_FB_OP, ARG_HCS);
                else retry_fail(SEQ_FB_APP, SEQ_SEND_OP);
            end
            SEQ_FB_OP: begin
                if (r == 8'h00) begin_cmd(SEQ_BLOCKLEN, ARG_BLKLEN);
                else retry_fail(SEQ_FB_APP, SEQ_SEND_OP);
            end
            SEQ_SEND_OP: begin
                if (r == 8'h00) begin_cmd(SEQ_BLOCKLEN, ARG_BLKLEN);
                else retry_fail(SEQ_SEND_OP, SEQ_IDLE);
            end
            SEQ_BLOCKLEN: begin
                if (r != 8'h00) begin
                    put_done(1'b0);
                end else begin
                    speed_on = 1'b1;
                    put_done(1'b1);
                end
            end
            default: begin
                put_done(r == 8'h00);
            end
        endcase
    endtask

    // Work out what one accepted transaction makes the block produce
    task automatic advance_host_model(input t_in_item it);
        case (it.op)
            OP_INIT: begin
                speed_on  = 1'b0;
                hc_flag   = 1'b0;
                retry_cnt = '0;
                begin_cmd(SEQ_GO_IDLE, 32'h0);
            end
            OP_READ, OP_WRITE: begin
                begin_cmd((it.op == OP_READ) ? SEQ_READ : SEQ_WRITE,
                          hc_flag ? it.sector : {it.sector[22:0], 9'd0});
            end
            default: begin
                if (seq_phase == SEQ_IDLE) begin
                    // byte from the card while idle: nothing comes out
                end else if (seq_phase == SEQ_R7 || seq_phase == SEQ_OCR_READ) begin
                    if (frame_pos < IDX_REPLY_LAST) begin
                        reply_b[frame_pos[1:0]] = it.rx_byte;
                        frame_pos = frame_pos + 3'd1;
                        put_byte(BYTE_IDLE);
                    end else if (seq_phase == SEQ_R7) begin
                        retry_cnt = '0;
                        if (reply_b[2][3:0] == 4'h1 && it.rx_byte == R7_CHECK)
                            begin_cmd(SEQ_HC_APP, 32'h0);
                        else
                            begin_cmd(SEQ_FB_APP, 32'h0);
                    end else begin
                        if (reply_b[0][6]) hc_flag = 1'b1;
                        begin_cmd(SEQ_BLOCKLEN, ARG_BLKLEN);
                    end
                end else if (frame_pos < IDX_CRC) begin
                    frame_pos = frame_pos + 3'd1;
                    put_byte(frame_out());
                end else if (frame_pos == IDX_CRC) begin
                    frame_pos = IDX_POLL;
                    poll_cnt  = '0;
                    put_byte(BYTE_IDLE);
                end else if (it.rx_byte == BYTE_IDLE && poll_cnt < POLL_LIMIT) begin
                    poll_cnt = poll_cnt + 16'd1;
                    put_byte(BYTE_IDLE);
                end else begin
                    on_card_reply(it.rx_byte);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_tally++;
        if (fail_tally <= 50)
            $display("mismatch at result %0d: %s got %h, want %h",
                     results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_host_out.size() == 0) begin
            report_mismatch("result with nothing awaited, tx_byte", got.tx_byte, 8'h00);
        end else begin
            want = awaited_host_out.pop_front();
            check_field("kind", 8'(got.kind), 8'(want.kind));
            check_field("tx_byte", got.tx_byte, want.tx_byte);
            check_field("select_active", 8'(got.select_active), 8'(want.select_active));
            check_field("full_speed", 8'(got.full_speed), 8'(want.full_speed));
            check_field("success", 8'(got.success), 8'(want.success));
            check_field("high_capacity", 8'(got.high_capacity), 8'(want.high_capacity));
        end
        results_seen++;
    endtask

    // Watch both channels; compare before predicting so a same-edge input cannot jump ahead
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            awaited_host_out.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_in_valid && !i_in_stall) advance_host_model(i_in_item);
        end
        o_pending    <= awaited_host_out.size();
        o_fail_count <= fail_tally;
    end

endmodule

`default_nettype wire

// ===== verif/sd_spi_card_init_sequencer_tb.sv =====
// Testbench top for the SD card SPI-mode sequencer: card-side stimulus and verdict.
`default_nettype none

module sd_spi_card_init_sequencer_tb;

    import sdspi_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    wire       in_stall;
    t_in_item  in_item;
    wire       out_valid;
    logic      out_stall;
    t_out_item out_item;
    wire [31:0] fails;
    wire [31:0] pending;

    // Stimulus knobs shared with the receiving process, and item counters
    bit no_idle     = 1'b0;
    int rx_hold_req = 0;
    int items_sent  = 0;
    int noise_items = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sd_spi_card_init_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    sd_spi_card_init_sequencer_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    // Offer one transaction after a random gap and hold it until taken
    task automatic offer(input t_op op, input logic [31:0] sector, input logic [7:0] rx);
        int gap;
        t_in_item it;
        it.op      = op;
        it.sector  = sector;
        it.rx_byte = rx;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        offer(OP_RX, $urandom, b);
    endtask

    // Card response helpers: idle-state R1, bad R1 for CMD55, non-zero R1
    function automatic logic [7:0] idle_r1();
        logic [7:0] v;
        v = 8'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [7:0] bad_idle_r1();
        logic [7:0] v;
        v = 8'($urandom_range(2, 254));
        return v;
    endfunction

    function automatic logic [7:0] bad_zero_r1();
        logic [7:0] v;
        v = 8'($urandom_range(1, 254));
        return v;
    endfunction

    function automatic logic [31:0] pick_sector();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h007F_FFFF;
            3:       return 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    // Clock through one command frame, zero to 40 busy polls, then the response
    task automatic frame_and_reply(input logic [7:0] resp);
        int polls;
        repeat (7) send_rx(8'($urandom));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: polls = 0;
            6, 7, 8:          polls = $urandom_range(1, 3);
            default:          polls = $urandom_range(4, 40);
        endcase
        repeat (polls) send_rx(BYTE_IDLE);
        send_rx(resp);
    endtask

    task automatic read4(input logic [7:0] b0, input logic [7:0] b1,
                         input logic [7:0] b2, input logic [7:0] b3);
        send_rx(b0);
        send_rx(b1);
        send_rx(b2);
        send_rx(b3);
    endtask

    // One CMD55 + ACMD41 try, failing on either command when not meant to succeed
    task automatic app_try(input bit succeed);
        if (succeed) begin
            frame_and_reply(idle_r1());
            frame_and_reply(8'h00);
        end else if ($urandom_range(0, 1)) begin
            frame_and_reply(bad_idle_r1());
        end else begin
            frame_and_reply(idle_r1());
            frame_and_reply(bad_zero_r1());
        end
    endtask

    task automatic app_loop(input int tries_failed, input bit succeed);
        repeat (tries_failed) app_try(1'b0);
        if (succeed) app_try(1'b1);
    endtask

    task automatic finish_blocklen();
        frame_and_reply(($urandom_range(0, 6) != 0) ? 8'h00 : bad_zero_r1());
    endtask

    // Full init flow along a random path: high capacity, bad CMD8 or bad R7
    task automatic run_init();
        int path;
        logic [7:0] b2;
        logic [7:0] b3;
        offer(OP_INIT, $urandom, 8'($urandom));
        frame_and_reply(8'($urandom_range(0, 254)));
        path = $urandom_range(0, 9);
        if (path <= 5) begin
            frame_and_reply(idle_r1());
            b2 = 8'($urandom);
            b2[3:0] = 4'h1;
            read4(8'($urandom), 8'($urandom), b2, R7_CHECK);
            app_loop($urandom_range(0, 3), 1'b1);
            if ($urandom_range(0, 4) != 0) begin
                frame_and_reply(8'h00);
                read4(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                frame_and_reply(bad_zero_r1());
            end
        end else begin
            if (path <= 7) begin
                frame_and_reply(bad_idle_r1());
            end else begin
                frame_and_reply(idle_r1());
                b2 = 8'($urandom);
                b3 = R7_CHECK;
                if ($urandom_range(0, 1))
                    b2[3:0] = 4'($urandom_range(2, 16));
                else
                    b3 = R7_CHECK + 8'($urandom_range(1, 255));
                read4(8'($urandom), 8'($urandom), b2, b3);
            end
            app_loop($urandom_range(0, 3), 1'b1);
        end
        finish_blocklen();
    endtask

    task automatic run_transfer();
        t_op op;
        op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        offer(op, pick_sector(), 8'($urandom));
        frame_and_reply(($urandom_range(0, 3) != 0) ? 8'h00 : bad_zero_r1());
    endtask

    // Stop offering and wait for every awaited result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic noise(input int n);
        repeat (n) offer(t_op'($urandom_range(0, 3)), $urandom, 8'($urandom));
        noise_items += n;
    endtask

    task automatic random_traffic(input int n);
        int goal;
        int pick;
        goal = items_sent - noise_items + n;
        while (items_sent - noise_items < goal) begin
            no_idle = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                run_init();
            end else if (pick < 15) begin
                run_transfer();
            end else if (pick < 17) begin
                // abandon a request part way through
                offer(t_op'($urandom_range(0, 2)), pick_sector(), 8'($urandom));
                repeat ($urandom_range(1, 10)) send_rx(8'($urandom));
            end else if (pick < 19) begin
                noise($urandom_range(1, 3));
            end else begin
                wait_drained();
                noise(2);
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiving side: random stall before each result, long hold-offs on request
    initial begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Hard stop for a hung run
    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int waited;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle byte, transfers before init, start while busy
        send_rx(8'h00);
        noise_items++;
        offer(OP_WRITE, 32'hFFFF_FFFF, 8'h00);
        repeat (7) send_rx(8'hFF);
        send_rx(8'hFF);
        send_rx(8'h00);
        offer(OP_READ, 32'h0000_0000, 8'hFF);
        repeat (3) send_rx(8'h5A);
        offer(OP_INIT, 32'hFFFF_FFFF, 8'hFF);
        repeat (7) send_rx(8'h00);
        send_rx(8'hFE);

        random_traffic(650);

        // Long receiver hold-off while the sender streams an init flow
        no_idle = 1'b1;
        rx_hold_req = 300;
        run_init();
        no_idle = 1'b0;
        wait_drained();
        noise(2);

        random_traffic(650);

        // Drain, then allow for the pipeline before the verdict
        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        $display("covered %0d transactions: init paths with retries and fallbacks,",
                 items_sent);
        $display("reads and writes, abandoned requests, a long hold-off; %0d mismatches",
                 fails);
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
